### sv/pmda_pkg.sv
// Package for the pedestal mean/deviation accumulator.
// Holds the fixed field widths, opcodes, register indexes and the sequencer state type.
// No dependencies.
package pmda_pkg;

	localparam int SUM_W      = 32;
	localparam int SQ_W       = 44;
	localparam int SQ_HALF    = 22;
	localparam int OUT_W      = 20;
	localparam int FRAC_W     = 8;
	localparam int VETO_W     = 13;
	localparam int CHAN_CFG_W = 10;
	localparam int CHAN_W     = 9;
	localparam int OP_W       = 2;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int MUL_W      = 32;

	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VETO     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd1;

	localparam logic RES_EVENT = 1'b0;
	localparam logic RES_STATS = 1'b1;

	localparam logic [VETO_W-1:0]     VETO_RESET     = 13'd75;
	localparam logic [CHAN_CFG_W-1:0] CHANNELS_RESET = 10'd331;
	localparam logic [OUT_W-1:0]      OUT_MAX        = '1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_EV_DONE,
		ST_Q_LOAD,
		ST_MUL_SS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_VAR,
		ST_DIV_MEAN,
		ST_SQRT,
		ST_DIV_DEV,
		ST_EMIT
	} state_t;

	// saturate a wide unsigned value to the 20-bit result fields
	function automatic logic [OUT_W-1:0] sat_out(input logic [63:0] v);
		logic [OUT_W-1:0] r;
		r = (v > 64'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
		return r;
	endfunction

endpackage

### sv/pmda_req_if.sv
// Request channel of the accumulator: samples, queries and clears.
// Depends on pmda_pkg for field widths.
interface pmda_req_if #(parameter int SAMPLE_BITS = 12);
	import pmda_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [OP_W-1:0]        opcode;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   last_in_event;
	logic [CHAN_W-1:0]      channel;
	modport source(output valid, opcode, sample, last_in_event, channel, input ready);
	modport sink(input valid, opcode, sample, last_in_event, channel, output ready);
endinterface

### sv/pmda_rsp_if.sv
// Result channel of the accumulator: event outcomes and channel statistics.
// Depends on pmda_pkg for field widths.
interface pmda_rsp_if;
	import pmda_pkg::*;
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic             event_accepted;
	logic [OUT_W-1:0] events_counted;
	logic [OUT_W-1:0] mean_value;
	logic [OUT_W-1:0] deviation_value;
	logic             stats_valid;
	modport source(output valid, result_kind, event_accepted, events_counted, mean_value,
		deviation_value, stats_valid, input ready);
	modport sink(input valid, result_kind, event_accepted, events_counted, mean_value,
		deviation_value, stats_valid, output ready);
endinterface

### sv/pmda_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### sv/pedestal_mean_deviation_accumulator.sv
// Pedestal mean/deviation accumulator: top level, sequencer and shared datapath.
// Depends on pmda_pkg, pmda_req_if, pmda_rsp_if and pmda_ram.
//
// Usage: samples arrive on req in channel order with opcode sample; the one marked
// last_in_event closes the event and yields one event outcome on rsp. A query
// yields one statistics item (mean and deviation, unsigned 12.8); a clear yields
// nothing. Configuration (veto threshold, channels in use) is written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Sequencing: an unmarked sample is taken in ST_IDLE. A marked sample of an accepted
// event walks the buffered channels, one read and one write-back of the sum RAM per
// channel through the shared multiplier, then ST_EV_DONE and ST_EMIT; a rejected event
// skips the walk. A query runs two restoring divisions and one square root, a bit per
// cycle through one shared subtractor; with no event counted it goes straight to
// ST_EMIT, and the second division is skipped when the variance is negative.
// Reset: after arst_n is released the sum RAM is swept to zero, one entry a cycle,
// all MAX_CHANNELS entries, with req.ready low. A clear runs the same sweep.
// A result waits in the output register while rsp.ready is low; unmarked samples
// are still taken meanwhile, anything that produces a result waits for it to go.
module pedestal_mean_deviation_accumulator #(
	parameter int MAX_CHANNELS = 512,
	parameter int SAMPLE_BITS  = 12,
	parameter int COUNT_BITS   = 20
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pmda_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pmda_pkg::CFG_DATA_W-1:0]    cfg_data,
	pmda_req_if.sink                           req,
	pmda_rsp_if.source                         rsp
);
	import pmda_pkg::*;

	localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PW      = $clog2(MAX_CHANNELS + 1);
	localparam int LW      = (PW > CHAN_CFG_W) ? PW : CHAN_CFG_W;
	localparam int VW      = (SAMPLE_BITS > VETO_W - 1) ? SAMPLE_BITS : VETO_W - 1;
	localparam int NUM_W   = SQ_W + COUNT_BITS;
	localparam int ROOT_W  = (NUM_W + 2 * FRAC_W + 1) / 2;
	localparam int D_W     = 2 * ROOT_W;
	localparam int SREM_W  = ROOT_W + 1;
	localparam int MEAN_DW = SUM_W + FRAC_W;
	localparam int DIV_W   = (ROOT_W > MEAN_DW) ? ROOT_W : MEAN_DW;
	localparam int ALU_W   = ROOT_W + 3;
	localparam int STEP_W  = $clog2(DIV_W);
	localparam int CMP_W   = (NUM_W > 2 * SUM_W) ? NUM_W : 2 * SUM_W;
	localparam int RAM_W   = SUM_W + SQ_W;

	state_t state_q, state_d;

	// control
	logic [VETO_W-1:0]     veto_thr_q;
	logic [CHAN_CFG_W-1:0] chan_cfg_q;
	logic [PW-1:0]         pos_q;
	logic                  vetoed_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [AW-1:0]         clr_idx_q;
	logic [PW-1:0]         idx_q;
	logic [PW-1:0]         used_q;
	logic                  accept_q;
	logic [STEP_W-1:0]     step_q;
	logic                  ov_q;

	// payload
	logic [SUM_W-1:0]          s_q;
	logic [SQ_W-1:0]           sq_q;
	logic [2*MUL_W-1:0]        ssq_q;
	logic [NUM_W-1:0]          num_q;
	logic                      neg_q;
	logic [D_W-1:0]            rad_q;
	logic [SREM_W-1:0]         srem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [COUNT_BITS-1:0]     rem_q;
	logic [DIV_W-1:0]          quo_q;
	logic                      res_kind_q;
	logic                      res_acc_q;
	logic [OUT_W-1:0]          res_mean_q;
	logic [OUT_W-1:0]          res_dev_q;
	logic                      res_valid_q;
	logic                      o_kind_q;
	logic                      o_acc_q;
	logic [OUT_W-1:0]          o_count_q;
	logic [OUT_W-1:0]          o_mean_q;
	logic [OUT_W-1:0]          o_dev_q;
	logic                      o_valid_q;

	// comb
	logic                   req_ready, req_fire, out_load;
	logic                   buf_we, buf_re, sum_we, sum_re;
	logic [AW-1:0]          sum_waddr, sum_raddr;
	logic [RAM_W-1:0]       sum_wdata, sum_rdata;
	logic [SAMPLE_BITS-1:0] buf_rdata;
	logic [MUL_W-1:0]       mul_a, mul_b;
	logic [2*MUL_W-1:0]     prod;
	logic [ALU_W-1:0]       alu_a, alu_b;
	logic [ALU_W:0]         alu_diff;
	logic                   alu_ge;
	logic [COUNT_BITS-1:0]  rem_nx;
	logic [DIV_W-1:0]       quo_nx;
	logic [SREM_W-1:0]      srem_nx;
	logic [ROOT_W-1:0]      root_nx;
	logic [PW-1:0]          lim, pos_next, used_now;
	logic                   pos_in_range, over_thr, vetoed_now, ev_accept, q_ok;
	logic                   div_last, sqrt_last;

	pmda_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_CHANNELS)) u_event_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (AW'(pos_q)),
		.wdata (req.sample),
		.re    (buf_re),
		.raddr (AW'(idx_q)),
		.rdata (buf_rdata)
	);

	// sum and sum of squares side by side: {square sum, sum}
	pmda_ram #(.WIDTH(RAM_W), .DEPTH(MAX_CHANNELS)) u_sums (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (sum_re),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	assign prod     = mul_a * mul_b;
	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_ge   = !alu_diff[ALU_W];
	assign rem_nx   = alu_ge ? COUNT_BITS'(alu_diff) : COUNT_BITS'(alu_a);
	assign quo_nx   = {quo_q[DIV_W-2:0], alu_ge};
	assign srem_nx  = alu_ge ? SREM_W'(alu_diff) : SREM_W'(alu_a);
	assign root_nx  = {root_q[ROOT_W-2:0], alu_ge};
	assign div_last  = (step_q == STEP_W'(DIV_W - 1));
	assign sqrt_last = (step_q == STEP_W'(ROOT_W - 1));

	assign lim = (LW'(chan_cfg_q) < LW'(MAX_CHANNELS)) ? PW'(chan_cfg_q) : PW'(MAX_CHANNELS);
	assign pos_in_range = (pos_q < lim);
	assign over_thr     = !veto_thr_q[VETO_W-1] &&
		(VW'(req.sample) > VW'(veto_thr_q[VETO_W-2:0]));
	assign vetoed_now   = vetoed_q || (pos_in_range && over_thr);
	assign pos_next     = pos_in_range ? pos_q + PW'(1) : pos_q;
	assign used_now     = (pos_next < lim) ? pos_next : lim;
	assign ev_accept    = !vetoed_now && (count_q != '1);
	assign q_ok         = (count_q != '0) && (32'(req.channel) < 32'(MAX_CHANNELS));

	assign req_fire  = req.valid && req_ready;
	assign req.ready = req_ready;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		out_load  = 1'b0;
		buf_we    = 1'b0;
		buf_re    = 1'b0;
		sum_we    = 1'b0;
		sum_re    = 1'b0;
		sum_waddr = AW'(idx_q);
		sum_raddr = AW'(idx_q);
		sum_wdata = '0;
		mul_a     = MUL_W'(buf_rdata);
		mul_b     = MUL_W'(buf_rdata);
		alu_a     = ALU_W'({rem_q, quo_q[DIV_W-1]});
		alu_b     = ALU_W'(count_q);
		unique case (state_q)
			ST_CLEAR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_idx_q;
				if (clr_idx_q == AW'(MAX_CHANNELS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_fire) begin
					unique case (req.opcode)
						OP_SAMPLE: begin
							buf_we = pos_in_range;
							if (req.last_in_event)
								state_d = ev_accept ? ST_WALK_RD : ST_EV_DONE;
						end
						OP_QUERY: begin
							if (q_ok) begin
								sum_re    = 1'b1;
								sum_raddr = AW'(req.channel);
								state_d   = ST_Q_LOAD;
							end else begin
								state_d = ST_EMIT;
							end
						end
						OP_CLEAR: state_d = ST_CLEAR;
						default: ;
					endcase
				end
			end
			ST_WALK_RD: begin
				if (idx_q == used_q) begin
					state_d = ST_EV_DONE;
				end else begin
					buf_re  = 1'b1;
					sum_re  = 1'b1;
					state_d = ST_WALK_WR;
				end
			end
			ST_WALK_WR: begin
				sum_we    = 1'b1;
				sum_wdata = {sum_rdata[RAM_W-1:SUM_W] + SQ_W'(prod),
					sum_rdata[SUM_W-1:0] + SUM_W'(buf_rdata)};
				state_d   = ST_WALK_RD;
			end
			ST_EV_DONE: state_d = ST_EMIT;
			ST_Q_LOAD:  state_d = ST_MUL_SS;
			ST_MUL_SS: begin
				mul_a   = s_q;
				mul_b   = s_q;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				mul_a   = MUL_W'(sq_q[SQ_HALF-1:0]);
				mul_b   = MUL_W'(count_q);
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				mul_a   = MUL_W'(sq_q[SQ_W-1:SQ_HALF]);
				mul_b   = MUL_W'(count_q);
				state_d = ST_VAR;
			end
			ST_VAR: state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: begin
				if (div_last) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				alu_a = ALU_W'({srem_q, rad_q[D_W-1 -: 2]});
				alu_b = ALU_W'({root_q, 2'b01});
				if (sqrt_last) state_d = neg_q ? ST_EMIT : ST_DIV_DEV;
			end
			ST_DIV_DEV: begin
				if (div_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!ov_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			veto_thr_q <= VETO_RESET;
			chan_cfg_q <= CHANNELS_RESET;
			pos_q      <= '0;
			vetoed_q   <= 1'b0;
			count_q    <= '0;
			clr_idx_q  <= '0;
			idx_q      <= '0;
			used_q     <= '0;
			accept_q   <= 1'b0;
			step_q     <= '0;
			ov_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_VETO:     veto_thr_q <= cfg_data[VETO_W-1:0];
					CFG_CHANNELS: chan_cfg_q <= cfg_data[CHAN_CFG_W-1:0];
				endcase
			end
			if (out_load) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: clr_idx_q <= clr_idx_q + AW'(1);
				ST_IDLE: begin
					if (req_fire && req.opcode == OP_SAMPLE) begin
						if (req.last_in_event) begin
							pos_q    <= '0;
							vetoed_q <= 1'b0;
							accept_q <= ev_accept;
							used_q   <= used_now;
							idx_q    <= '0;
						end else begin
							pos_q    <= pos_next;
							vetoed_q <= vetoed_now;
						end
					end
					if (req_fire && req.opcode == OP_CLEAR) begin
						count_q   <= '0;
						clr_idx_q <= '0;
					end
				end
				ST_WALK_WR: idx_q <= idx_q + PW'(1);
				ST_EV_DONE: begin
					if (accept_q) count_q <= count_q + COUNT_BITS'(1);
				end
				ST_VAR: step_q <= '0;
				ST_DIV_MEAN, ST_SQRT, ST_DIV_DEV: begin
					if ((state_q == ST_SQRT) ? sqrt_last : div_last) step_q <= '0;
					else step_q <= step_q + STEP_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && req.opcode == OP_QUERY) begin
					res_kind_q  <= RES_STATS;
					res_acc_q   <= 1'b0;
					res_mean_q  <= '0;
					res_dev_q   <= '0;
					res_valid_q <= q_ok;
				end
			end
			ST_EV_DONE: begin
				res_kind_q  <= RES_EVENT;
				res_acc_q   <= accept_q;
				res_mean_q  <= '0;
				res_dev_q   <= '0;
				res_valid_q <= 1'b0;
			end
			ST_Q_LOAD: begin
				s_q  <= sum_rdata[SUM_W-1:0];
				sq_q <= sum_rdata[RAM_W-1:SUM_W];
			end
			ST_MUL_SS: ssq_q <= prod;
			ST_MUL_LO: num_q <= NUM_W'(prod);
			ST_MUL_HI: num_q <= num_q + (NUM_W'(prod) << SQ_HALF);
			ST_VAR: begin
				neg_q <= CMP_W'(ssq_q) > CMP_W'(num_q);
				rad_q <= D_W'(num_q - NUM_W'(ssq_q)) << (2 * FRAC_W);
				quo_q <= DIV_W'({s_q, FRAC_W'(0)});
				rem_q <= '0;
			end
			ST_DIV_MEAN: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (div_last) begin
					res_mean_q <= sat_out(64'(quo_nx));
					srem_q     <= '0;
					root_q     <= '0;
				end
			end
			ST_SQRT: begin
				srem_q <= srem_nx;
				root_q <= root_nx;
				rad_q  <= rad_q << 2;
				if (sqrt_last) begin
					quo_q <= DIV_W'(root_nx);
					rem_q <= '0;
				end
			end
			ST_DIV_DEV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (div_last) res_dev_q <= sat_out(64'(quo_nx));
			end
			default: ;
		endcase
		if (out_load) begin
			o_kind_q  <= res_kind_q;
			o_acc_q   <= res_acc_q;
			o_count_q <= sat_out(64'(count_q));
			o_mean_q  <= res_mean_q;
			o_dev_q   <= res_dev_q;
			o_valid_q <= res_valid_q;
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.result_kind     = o_kind_q;
	assign rsp.event_accepted  = o_acc_q;
	assign rsp.events_counted  = o_count_q;
	assign rsp.mean_value      = o_mean_q;
	assign rsp.deviation_value = o_dev_q;
	assign rsp.stats_valid     = o_valid_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_CHANNELS))
		else $error("sample position past channel count");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK_WR |-> idx_q < used_q)
		else $error("walk index past buffered samples");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ov_q)
		else $error("result loaded but not presented");

	a_count_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_MEAN || state_q == ST_SQRT || state_q == ST_DIV_DEV)
		|=> $stable(count_q))
		else $error("event count moved during a query");

endmodule
